/* rtl/hyt_pkg.sv */
// Shared types, constants and helpers for the head yaw/pitch tracker.
// No dependencies; imported by hyt_cordic, head_yaw_pitch_tracker, hyt_checker and the testbench.
`default_nettype none
package hyt_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int CW           = 58;   // CORDIC datapath width
  localparam int ZW           = 26;   // angle accumulator, 1/65536 degree
  localparam int AW           = 18;   // rounded angle, 1/256 degree

  localparam int HALF_TURN    = 46080;
  localparam int FULL_TURN    = 92160;
  localparam int QUARTER_Z    = 90 * 65536;
  localparam int YAW_OFS      = 90 * 256;
  localparam int HEAD_CLAMP   = 75 * 256;
  localparam int IDLE_SLEW    = 10 * 256;

  localparam logic [29:0] KINV_Q30 = 30'd652032874;
  localparam int KINV_BITS    = 30;

  typedef enum logic [2:0] {
    S_IDLE, S_C1GO, S_C1, S_MUL, S_C2GO, S_C2, S_SLEW, S_CLAMP
  } hyt_state_t;

  typedef struct packed {
    logic done;
    logic busy;
  } cord_stat_t;

  function automatic logic [22:0] atan_tab(input logic [4:0] i);
    logic [22:0] r;
    case (i)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117304;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

  // single fold into [-180,180); input stays within one and a half turns
  function automatic logic signed [16:0] wrap_angle(input logic signed [19:0] v);
    logic signed [19:0] r;
    r = v;
    if (v < -20'sd46080)
      r = v + 20'sd92160;
    else if (v >= 20'sd46080)
      r = v - 20'sd92160;
    return r[16:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/head_yaw_pitch_tracker.sv */
// Head yaw/pitch tracker top level: sequencer, gain multiply, slew/clamp.
// Depends on hyt_pkg and hyt_cordic.
//
// Usage: one input beat per tick on in_valid/in_ready, one result beat
// (pitch, head_yaw_out) per tick on out_valid/out_ready.
// in_ready is high only while the sequencer is idle; one item is worked at
// a time. With look_valid set, the item goes through a CORDIC start step,
// the yaw CORDIC pass, the serial gain multiply (one bit of the constant
// per cycle), a second start step, the pitch CORDIC pass, then slew and
// clamp; without a look request it goes straight to slew and clamp. The
// sequencer returns to idle before the next accept, so no new beat is
// taken until the last one is through. The single CORDIC unit and the
// serial multiplier set the time per item.
// The result sits in an output register. If the receiver stalls, the
// finished item waits in the clamp step until the register frees, and no
// new beat is taken meanwhile.
// Synchronous reset clears the stored head yaw to 0, drops out_valid and
// returns the sequencer to idle.
`default_nettype none
module head_yaw_pitch_tracker import hyt_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               look_valid,
  input  wire logic signed [31:0] target_x,
  input  wire logic signed [31:0] target_y,
  input  wire logic signed [31:0] target_z,
  input  wire logic signed [31:0] self_x,
  input  wire logic signed [31:0] self_y,
  input  wire logic signed [31:0] self_z,
  input  wire logic        [12:0] eye_height,
  input  wire logic signed [16:0] body_yaw,
  input  wire logic               moving,
  input  wire logic        [15:0] yaw_step_max,
  input  wire logic        [15:0] pitch_step_max,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      pitch,
  output logic signed [16:0]      head_yaw_out
);

  hyt_state_t state, state_next;

  logic signed [32:0] dx, dz;
  logic signed [33:0] dy;
  logic               look;
  logic               mov;
  logic signed [16:0] body;
  logic [15:0]        ymax, pmax;
  logic signed [16:0] head_yaw;
  logic signed [19:0] yaw_t;
  logic signed [17:0] pitch_t;
  logic signed [16:0] head_new;
  logic [32:0]        mh;
  logic [23:0]        ml;
  logic [63:0]        acc1;
  logic [53:0]        acc2;
  logic [4:0]         k;

  logic               cord_start;
  logic signed [CW-1:0] cx, cy, cmag;
  logic signed [AW-1:0] cang;
  cord_stat_t         cstat;

  logic               accept;
  logic               out_free;
  logic [CW-1:0]      sd;
  logic [56:0]        m;
  logic signed [17:0] pneg;
  logic signed [17:0] plim;
  logic signed [19:0] tgt;
  logic signed [19:0] lim;
  logic signed [19:0] d;
  logic signed [16:0] slewed;
  logic signed [16:0] rel;
  logic signed [16:0] clamped;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign sd = acc1[63:6] + {34'b0, acc2[53:30]};
  assign m  = (cmag > 0) ? cmag[56:0] : '0;

  always_comb begin
    if (state == S_C1GO) begin
      cx = $signed({{5{dx[32]}}, dx, 20'b0});
      cy = $signed({{5{dz[32]}}, dz, 20'b0});
    end else begin
      cx = $signed(sd);
      cy = $signed({{4{dy[33]}}, dy, 20'b0});
    end
  end

  hyt_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cord_start),
    .x_in  (cx),
    .y_in  (cy),
    .stat  (cstat),
    .angle (cang),
    .mag   (cmag)
  );

  // pitch: negate, then limit to +-pitch_step_max
  always_comb begin
    pneg = -cang;
    plim = $signed({2'b0, pmax});
    if (pneg > plim)
      pneg = plim;
    if (pneg < -plim)
      pneg = -plim;
  end

  // slew toward target (look) or body yaw
  always_comb begin
    tgt = look ? yaw_t : 20'(body);
    lim = look ? $signed({4'b0, ymax}) : 20'(IDLE_SLEW);
    d   = 20'(wrap_angle(tgt - 20'(head_yaw)));
    if (d > lim)
      d = lim;
    if (d < -lim)
      d = -lim;
    slewed = wrap_angle(20'(head_yaw) + d);
  end

  always_comb begin
    rel     = wrap_angle(20'(head_new) - 20'(body));
    clamped = head_new;
    if (mov) begin
      if (rel < -17'(HEAD_CLAMP))
        clamped = wrap_angle(20'(body) - 20'(HEAD_CLAMP));
      if (rel > 17'(HEAD_CLAMP))
        clamped = wrap_angle(20'(body) + 20'(HEAD_CLAMP));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = look_valid ? S_C1GO : S_SLEW;
      S_C1GO:  state_next = S_C1;
      S_C1:    if (cstat.done) state_next = S_MUL;
      S_MUL:   if (k == 5'(KINV_BITS - 1)) state_next = S_C2GO;
      S_C2GO:  state_next = S_C2;
      S_C2:    if (cstat.done) state_next = S_SLEW;
      S_SLEW:  state_next = S_CLAMP;
      S_CLAMP: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cord_start = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_C1GO:  cord_start = 1'b1;
      S_C2GO:  cord_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_yaw  <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready)
        out_valid <= 1'b0;
      if (state == S_CLAMP && out_free) begin
        head_yaw     <= clamped;
        head_yaw_out <= clamped;
        pitch        <= look ? pitch_t[15:0] : '0;
        out_valid    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx   <= 33'(target_x) - 33'(self_x);
      dz   <= 33'(target_z) - 33'(self_z);
      dy   <= 34'(target_y) - (34'(self_y) + $signed({21'b0, eye_height}));
      look <= look_valid;
      mov  <= moving;
      body <= wrap_angle(20'(body_yaw));
      ymax <= yaw_step_max;
      pmax <= pitch_step_max;
    end
    if (state == S_C1 && cstat.done) begin
      yaw_t <= 20'(cang) - 20'(YAW_OFS);
      mh    <= m[56:24];
      ml    <= m[23:0];
      acc1  <= '0;
      acc2  <= '0;
      k     <= '0;
    end
    if (state == S_MUL) begin
      if (KINV_Q30[k]) begin
        acc1 <= acc1 + ({31'b0, mh} << k);
        acc2 <= acc2 + ({30'b0, ml} << k);
      end
      k <= k + 1'b1;
    end
    if (state == S_C2 && cstat.done)
      pitch_t <= pneg;
    if (state == S_SLEW)
      head_new <= slewed;
  end

  a_done_in_pass: assert property (@(posedge clk) disable iff (rst)
    (cstat.done || cstat.busy) |-> (state == S_C1 || state == S_C2))
    else $error("cordic active outside a pass");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready right after accept");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (head_yaw_out >= -17'sd46080 && head_yaw_out <= 17'sd46079))
    else $error("head yaw out of range");

  a_no_look_pitch: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLAMP && out_free && !look) |=> pitch == '0)
    else $error("pitch nonzero without look");

endmodule
`default_nettype wire

/* rtl/hyt_cordic.sv */
// Vectoring CORDIC, one micro-rotation per cycle, quadrant pre-rotation.
// Depends on hyt_pkg (widths, arctangent table).
`default_nettype none
module hyt_cordic import hyt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] x_in,
  input  wire logic signed [CW-1:0] y_in,
  output cord_stat_t                stat,
  output logic signed [AW-1:0]      angle,
  output logic signed [CW-1:0]      mag
);

  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic [CNT_W-1:0]     cnt;
  logic                 run;
  logic                 done;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] tab;
  logic signed [ZW-1:0] zr;

  assign xs  = x >>> cnt;
  assign ys  = y >>> cnt;
  assign tab = ZW'($signed({1'b0, atan_tab(5'(cnt))}));
  assign zr  = z + ZW'(128);

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= '0;
        if (x_in == '0 && y_in == '0) begin
          x    <= '0;
          y    <= '0;
          z    <= '0;
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x <= y_in;
              y <= -x_in;
              z <= ZW'(QUARTER_Z);
            end else begin
              x <= -y_in;
              y <= x_in;
              z <= -ZW'(QUARTER_Z);
            end
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end
      end else if (run) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + tab;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - tab;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.busy = run;
  assign angle     = zr[ZW-1:8];
  assign mag       = x;

endmodule
`default_nettype wire

/* sim/hyt_checker.sv */
// Checker for the head yaw/pitch tracker: watches both channels, predicts
// each tick's pitch and head yaw, and compares. Depends on hyt_pkg.
`timescale 1ns / 100ps
module hyt_checker import hyt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               look_valid,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] self_x,
  input  logic signed [31:0] self_y,
  input  logic signed [31:0] self_z,
  input  logic        [12:0] eye_height,
  input  logic signed [16:0] body_yaw,
  input  logic               moving,
  input  logic        [15:0] yaw_step_max,
  input  logic        [15:0] pitch_step_max,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] pitch,
  input  logic signed [16:0] head_yaw_out,
  output int                 err_cnt,
  output int                 pending
);

  typedef struct packed {
    logic [15:0] pitch;
    logic [16:0] yaw;
  } pose_t;

  pose_t  pose_q[$];
  longint head_model;

  localparam longint ATAN_TBL [16] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint wrap_deg(longint v);
    longint r;
    r = v % FULL_TURN;
    if (r < 0) r += FULL_TURN;
    if (r >= HALF_TURN) r -= FULL_TURN;
    return r;
  endfunction

  // vectoring pass; angle in 1/256 degree, gain-scaled magnitude out
  function automatic longint vec_angle(longint y, longint x, output longint mag);
    longint z, t, nx, ny;
    z = 0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return 0;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = QUARTER_Z;
      end else begin
        x = -y; y = t; z = -QUARTER_Z;
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_TBL[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_TBL[i];
      end
      x = nx;
      y = ny;
    end
    mag = x;
    return (z + 128) >>> 8;
  endfunction

  function automatic longint slew_to(longint from, longint to, longint lim);
    longint d;
    d = wrap_deg(to - from);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return wrap_deg(from + d);
  endfunction

  function automatic pose_t predict_pose();
    longint dx, dy, dz, gm, unused, yaw_t, ang, body, head, rel, pit, lim;
    logic [63:0] m, hdist;
    pose_t p;
    pit  = 0;
    body = wrap_deg(longint'(body_yaw));
    head = wrap_deg(head_model);
    if (look_valid) begin
      dx = (longint'(target_x) - longint'(self_x)) * 1048576;
      dy = (longint'(target_y) - (longint'(self_y) + longint'(eye_height))) * 1048576;
      dz = (longint'(target_z) - longint'(self_z)) * 1048576;
      yaw_t = vec_angle(dz, dx, gm) - YAW_OFS;
      m = gm > 0 ? gm : 0;
      hdist = (((m >> 24) * 64'(KINV_Q30)) >> 6)
            + (((m & 64'hFFFFFF) * 64'(KINV_Q30)) >> 30);
      ang = vec_angle(dy, longint'(hdist), unused);
      pit = -ang;
      lim = longint'(pitch_step_max);
      if (pit > lim) pit = lim;
      if (pit < -lim) pit = -lim;
      head = slew_to(head, yaw_t, longint'(yaw_step_max));
    end else begin
      head = slew_to(head, body, IDLE_SLEW);
    end
    rel = wrap_deg(head - body);
    if (moving) begin
      if (rel < -HEAD_CLAMP) head = body - HEAD_CLAMP;
      if (rel > HEAD_CLAMP) head = body + HEAD_CLAMP;
    end
    head = wrap_deg(head);
    head_model = head;
    p.pitch = pit[15:0];
    p.yaw   = head[16:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t exp_p;
    if (rst) begin
      head_model = 0;
      pose_q.delete();
      err_cnt = 0;
    end else begin
      // result first: it always belongs to an older beat
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          exp_p = pose_q.pop_front();
          if (pitch !== exp_p.pitch) begin
            $error("pitch: expected %0d actual %0d", $signed(exp_p.pitch), pitch);
            err_cnt++;
          end
          if (head_yaw_out !== exp_p.yaw) begin
            $error("head_yaw_out: expected %0d actual %0d", $signed(exp_p.yaw),
                   head_yaw_out);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) pose_q.push_back(predict_pose());
    end
    pending = pose_q.size();
  end

endmodule

/* sim/tb_head_yaw_pitch_tracker.sv */
// Testbench top for head_yaw_pitch_tracker: clock, reset, tick stimulus and
// receiver stalls. Depends on hyt_pkg, the RTL and hyt_checker.
`timescale 1ns / 100ps
module tb_head_yaw_pitch_tracker;
  import hyt_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic look_valid = 0, moving = 0;
  logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
  logic signed [31:0] self_x = 0, self_y = 0, self_z = 0;
  logic [12:0] eye_height = 0;
  logic signed [16:0] body_yaw = 0;
  logic [15:0] yaw_step_max = 0, pitch_step_max = 0;
  logic signed [15:0] pitch;
  logic signed [16:0] head_yaw_out;
  int err_cnt, pending;
  int send_idle_pct = 0, stall_pct = 0;
  logic took_beat = 0, hold_req = 0, hold_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  head_yaw_pitch_tracker u_top (.*);

  hyt_checker u_chk (.*);

  always @(posedge clk) took_beat <= in_valid && in_ready;

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ready = 0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic drive_tick(input logic lk, input logic [31:0] tx, ty, tz, sx, sy, sz,
                            input logic [12:0] eye, input logic [16:0] body,
                            input logic mv, input logic [15:0] ymax, pmax);
    look_valid = lk; target_x = tx; target_y = ty; target_z = tz;
    self_x = sx; self_y = sy; self_z = sz; eye_height = eye; body_yaw = body;
    moving = mv; yaw_step_max = ymax; pitch_step_max = pmax;
    in_valid = 1;
    do @(negedge clk); while (!took_beat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 80)) @(negedge clk);
    end
  endtask

  task automatic random_tick();
    logic [31:0] sx, sy, sz, tx, ty, tz;
    logic [16:0] body;
    logic [15:0] ymax, pmax;
    sx = $urandom; sy = $urandom; sz = $urandom;
    if ($urandom_range(9) < 7) begin
      // nearby target, the usual case
      tx = sx + $signed($urandom_range(8192)) - 4096;
      ty = sy + $signed($urandom_range(8192)) - 4096;
      tz = sz + $signed($urandom_range(8192)) - 4096;
    end else begin
      tx = $urandom; ty = $urandom; tz = $urandom;
    end
    body = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(92159) - 46080);
    ymax = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(6000));
    pmax = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(25000));
    drive_tick($urandom_range(9) < 7, tx, ty, tz, sx, sy, sz, 13'($urandom),
               body, 1'($urandom_range(1)), ymax, pmax);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 0;
    // directed: zero offset, axes, extremes, idle ticks, clamp
    drive_tick(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 46080, 46080);
    drive_tick(1, 256, 0, 0, 0, 0, 0, 0, 0, 0, 46080, 46080);
    drive_tick(1, -256, 0, 0, 0, 0, 0, 0, 0, 0, 46080, 46080);
    drive_tick(1, 0, 0, 256, 0, 0, 0, 0, 0, 0, 65535, 65535);
    drive_tick(1, 0, 0, -256, 0, 0, 0, 0, 0, 1, 46080, 46080);
    drive_tick(1, 0, 4096, 0, 0, 0, 0, 0, 0, 0, 46080, 46080);
    drive_tick(1, 0, -4096, 0, 0, 0, 0, 4096, 0, 0, 100, 100);
    drive_tick(1, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h7FFFFFFF, 13'h1FFF, 17'h0FFFF, 1, 16'hFFFF, 16'hFFFF);
    drive_tick(1, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h80000000, 0, 17'h10000, 0, 0, 0);
    drive_tick(1, -512, 100, -512, 0, 0, 0, 400, -46080, 1, 3000, 5000);
    drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 46079, 0, 0, 0);
    drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 46079, 1, 0, 0);
    drive_tick(0, 0, 0, 0, 0, 0, 0, 0, -46080, 1, 0, 0);
    drive_tick(1, 1000, 0, 1000, 0, 0, 0, 0, 40000, 1, 46080, 46080);
    drive_tick(1, 1000, 0, 1000, 0, 0, 0, 0, -30000, 1, 46080, 46080);
    drive_tick(0, 0, 0, 0, 0, 0, 0, 0, 17'h1FFFF, 1, 0, 0);
    drive_tick(1, 0, 0, 0, 0, 0, 0, 4096, 12345, 1, 65535, 65535);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 53 : 21) : 0;
      stall_pct     = (ph == 2 || ph == 3) ? (ph == 2 ? 53 : 21) : 0;
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 350; n++) random_tick();
    end
    in_valid = 0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #15ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
